@@ rtl/hann_windowed_stft_bins_defines.svh @@
// Assertion macros for the windowed STFT block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HANN_WINDOWED_STFT_BINS_DEFINES_SVH
`define HANN_WINDOWED_STFT_BINS_DEFINES_SVH

// Checked only outside reset.
`define HWSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define HWSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ rtl/hwsb_pkg.sv @@
// Shared constants, types and constant tables of the windowed STFT block.
// Depends on nothing; the files that use it refer to it by scoped names.
package hwsb_pkg;

  // Frame length must be a power of two (index arithmetic wraps by width).
  localparam int unsigned FrameLen    = 256;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned HalfFrame   = FrameLen / 2;
  localparam int unsigned PosBits     = $clog2(FrameLen);
  localparam int unsigned BinAddrBits = $clog2(HalfFrame);

  localparam int unsigned InBits      = 16;
  localparam int unsigned BinIdxBits  = 7;
  localparam int unsigned OutBits     = 24;
  localparam int unsigned PowerBits   = 48;
  localparam int unsigned AccBits     = 48;
  localparam int unsigned RamBits     = 2 * AccBits;
  localparam int unsigned TwBits      = 16;
  localparam int unsigned WinBits     = 16;
  localparam int unsigned XwBits      = SampleBits + 1;
  localparam int unsigned WinProdBits = SampleBits + WinBits + 1;
  localparam int unsigned ProdBits    = XwBits + TwBits;
  localparam int unsigned ScaleShift  = PosBits + 15;

  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  // Rounding toward zero: bias added to negative values before the shift.
  localparam logic signed [AccBits:0] BiasDc =
    (AccBits + 1)'((64'd1 << ScaleShift) - 64'd1);
  localparam logic signed [AccBits:0] BiasAc =
    (AccBits + 1)'((64'd1 << (ScaleShift - 1)) - 64'd1);
  localparam logic signed [AccBits:0] OutMax = (AccBits + 1)'(64'sd8388607);
  localparam logic signed [AccBits:0] OutMin = -(AccBits + 1)'(64'sd8388608);

  localparam longint unsigned PiHalfQ30 = 64'd1686629713;
  localparam longint unsigned OneQ30    = 64'd1 << 30;

  // One sample handed from the front end to the bin engine.
  typedef struct packed {
    logic signed [XwBits-1:0] xw;
    logic [PosBits-1:0]       pos;
    logic                     bank;
    logic                     emit;
  } job_t;

  typedef logic signed [TwBits-1:0] tw_tab_t [FrameLen];
  typedef logic [WinBits-1:0]       win_tab_t [FrameLen];

  function automatic longint q30_to_q15(input longint v);
    longint r;
    r = (v < 0) ? 64'sd0 : v;
    r = (r + 64'sd16384) >>> 15;
    return (r > 64'sd32767) ? 64'sd32767 : r;
  endfunction

  // Q15 sine or cosine of 2*pi*m/FrameLen, Taylor series in Q30.
  function automatic longint trig_q15(input longint unsigned m, input bit want_sin);
    longint unsigned a, q, r, x, x2, ts, tc;
    longint s, c, sq, cq, res;
    a  = (m % FrameLen) * 4;
    q  = a / FrameLen;
    r  = a % FrameLen;
    x  = (PiHalfQ30 * r) / FrameLen;
    x2 = (x * x) >> 30;
    ts = x;
    tc = OneQ30;
    s  = longint'(x);
    c  = longint'(OneQ30);
    // Terms x^(2n+1)/(2n+1)! and x^(2n)/(2n)!, each truncated, alternating signs.
    ts = ((ts * x2) >> 30) / 64'd6;
    tc = ((tc * x2) >> 30) / 64'd2;
    s  = s - longint'(ts);
    c  = c - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd20;
    tc = ((tc * x2) >> 30) / 64'd12;
    s  = s + longint'(ts);
    c  = c + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd42;
    tc = ((tc * x2) >> 30) / 64'd30;
    s  = s - longint'(ts);
    c  = c - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd72;
    tc = ((tc * x2) >> 30) / 64'd56;
    s  = s + longint'(ts);
    c  = c + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd110;
    tc = ((tc * x2) >> 30) / 64'd90;
    s  = s - longint'(ts);
    c  = c - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd156;
    tc = ((tc * x2) >> 30) / 64'd132;
    s  = s + longint'(ts);
    c  = c + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd210;
    tc = ((tc * x2) >> 30) / 64'd182;
    s  = s - longint'(ts);
    c  = c - longint'(tc);
    sq = q30_to_q15(s);
    cq = q30_to_q15(c);
    case (q)
      64'd0:   res = want_sin ? sq : cq;
      64'd1:   res = want_sin ? cq : -sq;
      64'd2:   res = want_sin ? -sq : -cq;
      default: res = want_sin ? -cq : sq;
    endcase
    return res;
  endfunction

  function automatic tw_tab_t gen_cos_tab();
    tw_tab_t t;
    for (int unsigned m = 0; m < FrameLen; m++) begin
      t[m] = TwBits'(trig_q15(longint'(m), 1'b0));
    end
    return t;
  endfunction

  function automatic tw_tab_t gen_sin_tab();
    tw_tab_t t;
    for (int unsigned m = 0; m < FrameLen; m++) begin
      t[m] = TwBits'(trig_q15(longint'(m), 1'b1));
    end
    return t;
  endfunction

  // Hann window: (32768 - cos) / 2.
  function automatic win_tab_t gen_win_tab();
    win_tab_t t;
    for (int unsigned m = 0; m < FrameLen; m++) begin
      t[m] = WinBits'((64'sd32768 - trig_q15(longint'(m), 1'b0)) >>> 1);
    end
    return t;
  endfunction

  localparam tw_tab_t  CosTab = gen_cos_tab();
  localparam tw_tab_t  SinTab = gen_sin_tab();
  localparam win_tab_t WinTab = gen_win_tab();

endpackage

@@ rtl/hann_windowed_stft_bins.sv @@
// Hann-windowed STFT, top level: sample front end, job queue, bin engine.
// Depends on hwsb_pkg, hwsb_front, hwsb_queue, hwsb_back (and hwsb_ram below it).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / sample_i) takes one signed audio
//   sample per item; frames are 256 samples long, counted from reset.
//   Output channel (out_valid_o / out_ready_i / bin_*) gives one bin item for
//   each of the first 128 samples of every frame after the first: sample p
//   yields bin p of the previous frame. last_bin_o marks bin 127.
//   The sample rate is set by the bin engine, which does one complex
//   multiply-accumulate per bin per cycle through a single read and a single
//   write port of the accumulator RAM, and takes a new sample only once its pass over all bins ends.
//   A bin item passes the window stage, the job queue, the readout stages and
//   the output register after its sample is accepted.
//   Reset clears position, bank and frame-ready flags and all handshakes; no
//   accumulator clearing is needed, since each frame overwrites its bank with
//   its first sample. When the receiver stalls, the finished bin waits in the
//   output register; the queue keeps filling and input backs up only once the
//   queue and the window stage are full.
module hann_windowed_stft_bins (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hwsb_pkg::InBits-1:0]         sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hwsb_pkg::BinIdxBits-1:0]     bin_index_o,
  output logic signed [hwsb_pkg::OutBits-1:0] bin_real_o,
  output logic signed [hwsb_pkg::OutBits-1:0] bin_imag_o,
  output logic [hwsb_pkg::PowerBits-1:0]      bin_power_o,
  output logic                                last_bin_o
);

  logic           push, full, pop, job_valid;
  hwsb_pkg::job_t push_job, head_job;

  // Front end: track frame position, window the sample, flag readout items.
  hwsb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .push_o    (push),
    .push_job_o(push_job),
    .full_i    (full)
  );

  // Decouple: hold windowed samples while the engine is busy.
  hwsb_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (job_valid),
    .head_o    (head_job)
  );

  // Engine: accumulate into the active bank, read out the finished bank.
  hwsb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .bin_index_o(bin_index_o),
    .bin_real_o (bin_real_o),
    .bin_imag_o (bin_imag_o),
    .bin_power_o(bin_power_o),
    .last_bin_o (last_bin_o)
  );

endmodule

@@ rtl/hwsb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module hwsb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hwsb_queue.sv @@
// Short job queue between the sample front end and the bin engine.
// Depends on hwsb_pkg.
module hwsb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hwsb_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hwsb_pkg::job_t head_o
);

  hwsb_pkg::job_t mem_q [hwsb_pkg::QueueDepth];
  logic [hwsb_pkg::QueuePtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [hwsb_pkg::QueueCntBits-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == hwsb_pkg::QueueCntBits'(hwsb_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + hwsb_pkg::QueuePtrBits'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + hwsb_pkg::QueuePtrBits'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + hwsb_pkg::QueueCntBits'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - hwsb_pkg::QueueCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/hwsb_front.sv @@
// Sample front end: frame position, bank and readout flags, Hann windowing.
// Depends on hwsb_pkg.
module hwsb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hwsb_pkg::InBits-1:0] sample_i,
  output logic                      push_o,
  output hwsb_pkg::job_t            push_job_o,
  input  logic                      full_i
);

  logic [hwsb_pkg::PosBits-1:0] pos_q, pos_d;
  logic bank_q, bank_d, ready_q, ready_d;
  logic a_valid_q, a_valid_d;
  logic signed [hwsb_pkg::SampleBits-1:0] a_smp_q;
  logic [hwsb_pkg::WinBits-1:0] a_win_q;
  logic [hwsb_pkg::PosBits-1:0] a_pos_q;
  logic a_bank_q, a_emit_q;
  logic accept;
  logic signed [hwsb_pkg::WinProdBits-1:0] prod;
  logic signed [hwsb_pkg::WinProdBits-1:0] prod_shr;

  assign push_o     = a_valid_q && !full_i;
  assign in_ready_o = !a_valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // floor(sample * w / 2^15)
  assign prod     = a_smp_q * $signed({1'b0, a_win_q});
  assign prod_shr = prod >>> 15;

  assign push_job_o.xw   = prod_shr[hwsb_pkg::XwBits-1:0];
  assign push_job_o.pos  = a_pos_q;
  assign push_job_o.bank = a_bank_q;
  assign push_job_o.emit = a_emit_q;

  always_comb begin
    pos_d     = pos_q;
    bank_d    = bank_q;
    ready_d   = ready_q;
    a_valid_d = a_valid_q;
    if (push_o) begin
      a_valid_d = 1'b0;
    end
    if (accept) begin
      a_valid_d = 1'b1;
      pos_d     = pos_q + hwsb_pkg::PosBits'(1);
      if (pos_q == hwsb_pkg::PosBits'(hwsb_pkg::FrameLen - 1)) begin
        bank_d  = !bank_q;
        ready_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      bank_q    <= 1'b0;
      ready_q   <= 1'b0;
      a_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      bank_q    <= bank_d;
      ready_q   <= ready_d;
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_smp_q  <= $signed(sample_i[hwsb_pkg::SampleBits-1:0]);
      a_win_q  <= hwsb_pkg::WinTab[pos_q];
      a_pos_q  <= pos_q;
      a_bank_q <= bank_q;
      a_emit_q <= ready_q && (pos_q < hwsb_pkg::PosBits'(hwsb_pkg::HalfFrame));
    end
  end

endmodule

@@ rtl/hwsb_back.sv @@
// Bin engine: per-sample pass of complex MACs over the active accumulator bank,
// plus readout, scaling and power of one finished bin. Depends on hwsb_pkg, hwsb_ram.
module hwsb_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 job_valid_i,
  input  hwsb_pkg::job_t                       job_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hwsb_pkg::BinIdxBits-1:0]      bin_index_o,
  output logic signed [hwsb_pkg::OutBits-1:0]  bin_real_o,
  output logic signed [hwsb_pkg::OutBits-1:0]  bin_imag_o,
  output logic [hwsb_pkg::PowerBits-1:0]       bin_power_o,
  output logic                                 last_bin_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } back_state_e;

  localparam int unsigned AB = hwsb_pkg::AccBits;

  back_state_e state_q, state_d;
  logic [hwsb_pkg::BinAddrBits-1:0] k_q, k_d;
  logic [hwsb_pkg::PosBits-1:0]     idx_q, idx_d;
  logic signed [hwsb_pkg::XwBits-1:0] xw_q;
  logic [hwsb_pkg::PosBits-1:0]     pos_q;
  logic bank_q, first_q;

  // MAC pipeline
  logic s1_valid_q, s2_valid_q;
  logic [hwsb_pkg::BinAddrBits-1:0] s1_k_q, s2_k_q;
  logic s1_bank_q, s2_bank_q, s1_first_q, s2_first_q;
  logic signed [hwsb_pkg::XwBits-1:0] s1_xw_q;
  logic signed [hwsb_pkg::TwBits-1:0] cos_q, sin_q;
  logic signed [hwsb_pkg::ProdBits-1:0] s2_pr_q, s2_pi_q;
  logic [hwsb_pkg::RamBits-1:0] s2_acc_q;

  // Readout pipeline
  logic r1_valid_q, r2_valid_q, r3_valid_q;
  logic r1_bank_q;
  logic [hwsb_pkg::PosBits-1:0] r1_pos_q, r2_pos_q, r3_pos_q;
  logic signed [hwsb_pkg::OutBits-1:0] r2_re_q, r2_im_q, r3_re_q, r3_im_q;
  logic signed [hwsb_pkg::PowerBits-1:0] r3_sq_re_q, r3_sq_im_q;

  logic out_valid_q, out_valid_d;
  logic [hwsb_pkg::BinIdxBits-1:0] out_idx_q;
  logic signed [hwsb_pkg::OutBits-1:0] out_re_q, out_im_q;
  logic [hwsb_pkg::PowerBits-1:0] out_pow_q;
  logic out_last_q;

  logic [hwsb_pkg::BinAddrBits-1:0] raddr;
  logic [1:0] we;
  logic [hwsb_pkg::RamBits-1:0] wdata;
  logic [hwsb_pkg::RamBits-1:0] rdata [2];
  logic signed [AB-1:0] base_re, base_im, new_re, new_im;
  logic [hwsb_pkg::RamBits-1:0] ro_word;
  logic r1_dc;

  function automatic logic signed [hwsb_pkg::OutBits-1:0] scale_part(
    input logic signed [hwsb_pkg::AccBits-1:0] v,
    input logic                                dc
  );
    logic signed [hwsb_pkg::AccBits:0] ext, biased, shifted;
    ext = {v[hwsb_pkg::AccBits-1], v};
    if (dc) begin
      biased  = v[hwsb_pkg::AccBits-1] ? ext + hwsb_pkg::BiasDc : ext;
      shifted = biased >>> hwsb_pkg::ScaleShift;
    end else begin
      biased  = v[hwsb_pkg::AccBits-1] ? ext + hwsb_pkg::BiasAc : ext;
      shifted = biased >>> (hwsb_pkg::ScaleShift - 1);
    end
    if (shifted > hwsb_pkg::OutMax) begin
      shifted = hwsb_pkg::OutMax;
    end else if (shifted < hwsb_pkg::OutMin) begin
      shifted = hwsb_pkg::OutMin;
    end
    return shifted[hwsb_pkg::OutBits-1:0];
  endfunction

  // Pop when idle; pop a readout item only when the output register is free.
  assign pop_o = (state_q == StIdle) && job_valid_i && (!job_i.emit || !out_valid_q);

  // Both banks share one read address: the readout bin on pop, bin k while running.
  assign raddr = (state_q == StRun) ? k_q : job_i.pos[hwsb_pkg::BinAddrBits-1:0];

  assign base_re = s2_first_q ? '0 : s2_acc_q[2*AB-1:AB];
  assign base_im = s2_first_q ? '0 : s2_acc_q[AB-1:0];
  assign new_re  = base_re + {{(AB - hwsb_pkg::ProdBits){s2_pr_q[hwsb_pkg::ProdBits-1]}},
                              s2_pr_q};
  assign new_im  = base_im - {{(AB - hwsb_pkg::ProdBits){s2_pi_q[hwsb_pkg::ProdBits-1]}},
                              s2_pi_q};
  assign wdata   = {new_re, new_im};
  assign we[0]   = s2_valid_q && !s2_bank_q;
  assign we[1]   = s2_valid_q && s2_bank_q;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    hwsb_ram #(
      .Width(hwsb_pkg::RamBits),
      .Depth(hwsb_pkg::HalfFrame)
    ) u_acc_ram (
      .clk_i  (clk_i),
      .we_i   (we[b]),
      .waddr_i(s2_k_q),
      .wdata_i(wdata),
      .raddr_i(raddr),
      .rdata_o(rdata[b])
    );
  end

  assign ro_word = rdata[r1_bank_q];
  assign r1_dc   = (r1_pos_q == '0);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    idx_d   = idx_q;
    case (state_q)
      StIdle: begin
        if (pop_o) begin
          state_d = StRun;
          k_d     = '0;
          idx_d   = '0;
        end
      end
      StRun: begin
        k_d   = k_q + hwsb_pkg::BinAddrBits'(1);
        idx_d = idx_q + pos_q;
        if (k_q == hwsb_pkg::BinAddrBits'(hwsb_pkg::HalfFrame - 1)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (r3_valid_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      r1_valid_q  <= 1'b0;
      r2_valid_q  <= 1'b0;
      r3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      s1_valid_q  <= (state_q == StRun);
      s2_valid_q  <= s1_valid_q;
      r1_valid_q  <= pop_o && job_i.emit;
      r2_valid_q  <= r1_valid_q;
      r3_valid_q  <= r2_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      xw_q      <= job_i.xw;
      pos_q     <= job_i.pos;
      bank_q    <= job_i.bank;
      first_q   <= (job_i.pos == '0);
      r1_bank_q <= !job_i.bank;
      r1_pos_q  <= job_i.pos;
    end
    // issue: twiddle lookup for bin k
    s1_k_q     <= k_q;
    s1_bank_q  <= bank_q;
    s1_first_q <= first_q;
    s1_xw_q    <= xw_q;
    cos_q      <= hwsb_pkg::CosTab[idx_q];
    sin_q      <= hwsb_pkg::SinTab[idx_q];
    // multiply, hold accumulator word
    s2_k_q     <= s1_k_q;
    s2_bank_q  <= s1_bank_q;
    s2_first_q <= s1_first_q;
    s2_pr_q    <= s1_xw_q * cos_q;
    s2_pi_q    <= s1_xw_q * sin_q;
    s2_acc_q   <= rdata[s1_bank_q];
    // readout: scale, square, sum
    r2_re_q    <= scale_part(ro_word[2*AB-1:AB], r1_dc);
    r2_im_q    <= scale_part(ro_word[AB-1:0], r1_dc);
    r2_pos_q   <= r1_pos_q;
    r3_re_q    <= r2_re_q;
    r3_im_q    <= r2_im_q;
    r3_sq_re_q <= r2_re_q * r2_re_q;
    r3_sq_im_q <= r2_im_q * r2_im_q;
    r3_pos_q   <= r2_pos_q;
    if (r3_valid_q) begin
      out_idx_q  <= hwsb_pkg::BinIdxBits'(r3_pos_q);
      out_re_q   <= r3_re_q;
      out_im_q   <= r3_im_q;
      out_pow_q  <= r3_sq_re_q + r3_sq_im_q;
      out_last_q <= (r3_pos_q == hwsb_pkg::PosBits'(hwsb_pkg::HalfFrame - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = out_idx_q;
  assign bin_real_o  = out_re_q;
  assign bin_imag_o  = out_im_q;
  assign bin_power_o = out_pow_q;
  assign last_bin_o  = out_last_q;

endmodule

@@ rtl/hwsb_checker.sv @@
// Port-level checks of the windowed STFT block, bound to its top level.
// Depends on hwsb_pkg and hann_windowed_stft_bins_defines.svh.
`include "hann_windowed_stft_bins_defines.svh"

module hwsb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [hwsb_pkg::BinIdxBits-1:0]     bin_index_o,
  input logic signed [hwsb_pkg::OutBits-1:0] bin_real_o,
  input logic signed [hwsb_pkg::OutBits-1:0] bin_imag_o,
  input logic [hwsb_pkg::PowerBits-1:0]      bin_power_o,
  input logic                                last_bin_o
);

  logic [hwsb_pkg::BinIdxBits-1:0] exp_q;
  logic signed [hwsb_pkg::PowerBits-1:0] re_w, im_w;
  logic [hwsb_pkg::PowerBits-1:0] power_exp;
  logic stalled;

  assign re_w      = hwsb_pkg::PowerBits'(bin_real_o);
  assign im_w      = hwsb_pkg::PowerBits'(bin_imag_o);
  assign power_exp = re_w * re_w + im_w * im_w;
  assign stalled   = out_valid_o && !out_ready_i;

  // Expected bin number: advance on each delivered item, wrap after the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_q <= last_bin_o ? '0 : exp_q + hwsb_pkg::BinIdxBits'(1);
    end
  end

  `HWSB_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "output valid in reset")
  `HWSB_ASSERT(a_out_hold, stalled |=> out_valid_o && $stable(bin_index_o) && $stable(bin_real_o) && $stable(bin_imag_o) && $stable(bin_power_o), "stalled bin item changed")
  `HWSB_ASSERT(a_bin_order, out_valid_o |-> bin_index_o == exp_q, "bins out of order")
  `HWSB_ASSERT(a_last_mark, out_valid_o |-> last_bin_o == (bin_index_o == hwsb_pkg::BinIdxBits'(hwsb_pkg::HalfFrame - 1)), "last bin mark wrong")
  `HWSB_ASSERT(a_power, out_valid_o |-> bin_power_o == power_exp, "power does not match parts")

endmodule

bind hann_windowed_stft_bins hwsb_checker u_checker (.*);

@@ bench/hann_windowed_stft_bins_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for hann_windowed_stft_bins: frames of audio samples go in and
// windowed DFT bins come out. Each bin is compared with a bit-exact predictor kept here.
// Depends on hwsb_pkg (port widths, frame size) and the hann_windowed_stft_bins RTL.
module hann_windowed_stft_bins_tb;

  localparam int unsigned FrameN  = hwsb_pkg::FrameLen;
  localparam int unsigned NumBins = hwsb_pkg::HalfFrame;

  // Quarter turn and unity in Q30, the fixed-point grid of the twiddle series.
  localparam longint unsigned QuarterTurnQ30 = 64'd1686629713;
  localparam longint unsigned UnityQ30       = 64'd1 << 30;

  localparam int unsigned NumRandom    = 1575;
  localparam int unsigned DrainCycles  = 800;
  localparam int unsigned LongHold     = 2500;
  localparam int unsigned HoldAtResult = 150;
  localparam int unsigned ModeSpan     = 64;

  // Full-scale rails, zero crossings and walking patterns for the opening items.
  localparam logic [15:0] CornerSamples [25] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE,
    16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h4000, 16'hC000, 16'h7FFF,
    16'h7FFF, 16'h8000, 16'h8000, 16'h0100, 16'hFEFF, 16'h1234, 16'hEDCB,
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF
  };

  // Character of one frame of random audio.
  typedef enum logic [2:0] {
    STYLE_NOISE,
    STYLE_RAILS,
    STYLE_QUIET,
    STYLE_DC,
    STYLE_SQUARE
  } frame_style_e;

  // How eagerly a side of the handshake idles.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_mode_e;

  typedef struct {
    logic [hwsb_pkg::BinIdxBits-1:0]     idx;
    logic signed [hwsb_pkg::OutBits-1:0] re;
    logic signed [hwsb_pkg::OutBits-1:0] im;
    logic [hwsb_pkg::PowerBits-1:0]      pwr;
    logic                                last;
  } bin_item_t;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic [hwsb_pkg::InBits-1:0]         sample_i    = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [hwsb_pkg::BinIdxBits-1:0]     bin_index_o;
  logic signed [hwsb_pkg::OutBits-1:0] bin_real_o;
  logic signed [hwsb_pkg::OutBits-1:0] bin_imag_o;
  logic [hwsb_pkg::PowerBits-1:0]      bin_power_o;
  logic                                last_bin_o;

  // Twiddle and window tables, Q1.15.
  int cos_q15  [FrameN];
  int sin_q15  [FrameN];
  int hann_q15 [FrameN];

  // Predictor state: two accumulator banks, position in the frame, bank being filled.
  logic [hwsb_pkg::AccBits-1:0] acc_re [2][NumBins];
  logic [hwsb_pkg::AccBits-1:0] acc_im [2][NumBins];
  int unsigned                  frame_pos        = 0;
  bit                           fill_bank        = 1'b0;
  bit                           prior_frame_done = 1'b0;

  logic [hwsb_pkg::InBits-1:0] samples_to_send [$];
  bin_item_t                   bins_due [$];

  int unsigned err_count     = 0;
  int unsigned samples_taken = 0;
  int unsigned bins_seen     = 0;
  int unsigned send_gap      = 0;
  int unsigned hold_left     = 0;
  idle_mode_e  send_mode     = IDLE_NONE;
  idle_mode_e  recv_mode     = IDLE_LIGHT;

  hann_windowed_stft_bins dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bin_index_o (bin_index_o),
    .bin_real_o  (bin_real_o),
    .bin_imag_o  (bin_imag_o),
    .bin_power_o (bin_power_o),
    .last_bin_o  (last_bin_o)
  );

  always #5 clk_i = ~clk_i;

  // Round a Q30 value half up to Q15, clamped to [0, 32767].
  function automatic longint q30_round_q15(input longint v);
    longint r;
    r = (v < 0) ? 64'sd0 : v;
    r = (r + 64'sd16384) >>> 15;
    return (r > 64'sd32767) ? 64'sd32767 : r;
  endfunction

  // Q15 cosine and sine of 2*pi*m/FrameN: Taylor series over the in-quadrant angle,
  // each term truncated, then the quadrant folds in swap and sign.
  function automatic void twiddle_q15(input int unsigned m, output int c_out, output int s_out);
    longint unsigned ang, quad, rem, x, x2, term_s, term_c, n;
    longint          sum_s, sum_c, sq, cq;
    ang    = longint'(m % FrameN) * 4;
    quad   = ang / FrameN;
    rem    = ang % FrameN;
    x      = (QuarterTurnQ30 * rem) / FrameN;
    x2     = (x * x) >> 30;
    term_s = x;
    term_c = UnityQ30;
    sum_s  = longint'(x);
    sum_c  = longint'(UnityQ30);
    for (n = 1; n <= 7; n++) begin
      term_s = ((term_s * x2) >> 30) / ((2 * n) * (2 * n + 1));
      term_c = ((term_c * x2) >> 30) / ((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum_s = sum_s - longint'(term_s);
        sum_c = sum_c - longint'(term_c);
      end else begin
        sum_s = sum_s + longint'(term_s);
        sum_c = sum_c + longint'(term_c);
      end
    end
    sq = q30_round_q15(sum_s);
    cq = q30_round_q15(sum_c);
    case (quad)
      64'd0: begin
        s_out = int'(sq);
        c_out = int'(cq);
      end
      64'd1: begin
        s_out = int'(cq);
        c_out = -int'(sq);
      end
      64'd2: begin
        s_out = -int'(sq);
        c_out = -int'(cq);
      end
      default: begin
        s_out = -int'(cq);
        c_out = int'(sq);
      end
    endcase
  endfunction

  // Scale an accumulated bin by 2/FrameN (bin 0 by 1/FrameN), truncate, saturate.
  function automatic longint scale_bin(input logic [hwsb_pkg::AccBits-1:0] acc,
                                       input int unsigned k);
    longint v;
    v = longint'($signed(acc));
    if (k != 0) begin
      v = v * 2;
    end
    v = v / (longint'(FrameN) * 64'sd32768);
    if (v > 64'sd8388607) begin
      v = 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      v = -64'sd8388608;
    end
    return v;
  endfunction

  // Window one sample into the bank being filled; emit bin p of the finished bank first.
  task automatic fold_sample_into_bins(input logic [hwsb_pkg::InBits-1:0] raw);
    longint                       smp, xw, re, im;
    logic [hwsb_pkg::AccBits-1:0] base_re, base_im;
    int unsigned                  k, idx;
    bin_item_t                    due;
    smp = longint'($signed(raw));
    xw  = (smp * hann_q15[frame_pos]) >>> 15;
    if (prior_frame_done && frame_pos < NumBins) begin
      re       = scale_bin(acc_re[fill_bank ^ 1'b1][frame_pos], frame_pos);
      im       = scale_bin(acc_im[fill_bank ^ 1'b1][frame_pos], frame_pos);
      due.idx  = hwsb_pkg::BinIdxBits'(frame_pos);
      due.re   = hwsb_pkg::OutBits'(re);
      due.im   = hwsb_pkg::OutBits'(im);
      due.pwr  = hwsb_pkg::PowerBits'(re * re + im * im);
      due.last = (frame_pos == NumBins - 1);
      bins_due.push_back(due);
    end
    // Position zero starts the bank over instead of adding to stale sums.
    for (k = 0; k < NumBins; k++) begin
      idx     = (frame_pos * k) % FrameN;
      base_re = (frame_pos == 0) ? '0 : acc_re[fill_bank][k];
      base_im = (frame_pos == 0) ? '0 : acc_im[fill_bank][k];
      acc_re[fill_bank][k] = base_re + hwsb_pkg::AccBits'(xw * cos_q15[idx]);
      acc_im[fill_bank][k] = base_im - hwsb_pkg::AccBits'(xw * sin_q15[idx]);
    end
    frame_pos++;
    if (frame_pos == FrameN) begin
      frame_pos        = 0;
      fill_bank        = fill_bank ^ 1'b1;
      prior_frame_done = 1'b1;
    end
  endtask

  function automatic int unsigned pick_wait(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default:    return $urandom_range(0, 16);
    endcase
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      err_count++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Sender: hold each item until taken, then idle for a drawn number of cycles.
  always @(posedge clk_i) begin : drive_samples
    bit          taken;
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        fold_sample_into_bins(sample_i);
        samples_taken++;
        if (samples_taken % ModeSpan == 0) begin
          send_mode = idle_mode_e'($urandom_range(0, 2));
        end
        gap = pick_wait(send_mode);
        // Back-to-back when no gap is drawn, so valid never dips between items.
        if (gap == 0 && samples_to_send.size() != 0) begin
          sample_i <= samples_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          send_gap   <= gap;
        end
      end else if (!in_valid_i) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (samples_to_send.size() != 0) begin
          sample_i   <= samples_to_send.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Receiver: check each bin item, then hold ready low for a drawn number of cycles.
  // Once, the hold is long enough for the block to fill up and stall its input.
  always @(posedge clk_i) begin : collect_bins
    bin_item_t   due;
    int unsigned nxt;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      nxt = (hold_left != 0) ? hold_left - 1 : 0;
      if (out_valid_o && out_ready_i) begin
        bins_seen++;
        if (bins_due.size() == 0) begin
          err_count++;
          $display("%0t ns: bin item with none expected: expected nothing, actual index %0d",
                   $time, bin_index_o);
        end else begin
          due = bins_due.pop_front();
          check_field("bin_index", longint'(due.idx), longint'(bin_index_o));
          check_field("bin_real", longint'(due.re), longint'(bin_real_o));
          check_field("bin_imag", longint'(due.im), longint'(bin_imag_o));
          check_field("bin_power", longint'(due.pwr), longint'(bin_power_o));
          check_field("last_bin", longint'(due.last), longint'(last_bin_o));
        end
        if (bins_seen % ModeSpan == 0) begin
          recv_mode = idle_mode_e'($urandom_range(0, 2));
        end
        nxt = (bins_seen == HoldAtResult) ? LongHold : pick_wait(recv_mode);
      end
      hold_left   <= nxt;
      out_ready_i <= (nxt == 0);
    end
  end

  initial begin : run_bench
    int unsigned  m, n, pos, period;
    int           c, s, amp;
    logic [15:0]  smp, dc_level;
    frame_style_e style;
    for (m = 0; m < FrameN; m++) begin
      twiddle_q15(m, c, s);
      cos_q15[m]  = c;
      sin_q15[m]  = s;
      hann_q15[m] = (32768 - c) >>> 1;
    end

    // Directed opening: extremes and bit patterns, all inside the first frame.
    foreach (CornerSamples[i]) begin
      samples_to_send.push_back(CornerSamples[i]);
    end

    // Random frames, each with its own character, plus stray full-range noise.
    style    = STYLE_NOISE;
    dc_level = '0;
    period   = 1;
    amp      = 0;
    for (n = 0; n < NumRandom; n++) begin
      pos = (n + $size(CornerSamples)) % FrameN;
      if (n == 0 || pos == 0) begin
        style    = frame_style_e'($urandom_range(0, 4));
        dc_level = 16'($urandom);
        period   = $urandom_range(1, 32);
        amp      = $urandom_range(0, 32767);
      end
      case (style)
        STYLE_NOISE:  smp = 16'($urandom);
        STYLE_RAILS:  smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        STYLE_QUIET:  smp = 16'($urandom_range(0, 16) - 8);
        STYLE_DC:     smp = dc_level;
        default:      smp = ((pos / period) % 2) ? 16'(-amp) : 16'(amp);
      endcase
      if ($urandom_range(0, 31) == 0) begin
        smp = 16'($urandom);
      end
      samples_to_send.push_back(smp);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(posedge clk_i);
    end while (samples_to_send.size() != 0 || in_valid_i || bins_due.size() != 0);
    // Let samples that emit nothing clear the engine; late extra bins get flagged here.
    repeat (DrainCycles) @(posedge clk_i);

    if (bins_due.size() != 0) begin
      err_count += bins_due.size();
      $display("%0t ns: bins never delivered: expected %0d more, actual 0",
               $time, bins_due.size());
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: end the run as failed if it is still going.
  initial begin : watchdog
    #(64'd10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hwsb_pkg.sv
rtl/hwsb_ram.sv
rtl/hwsb_queue.sv
rtl/hwsb_front.sv
rtl/hwsb_back.sv
rtl/hann_windowed_stft_bins.sv
rtl/hwsb_checker.sv
bench/hann_windowed_stft_bins_tb.sv
